// ----- design/dsw_pkg.sv -----
// dsw_pkg: shared constants, codes and types of the drive stall watchdog
package dsw_pkg;

   // sizing
   localparam int JOINT_COUNT = 16;
   localparam int RPDO_COUNT  = 4;
   localparam int JIDX_W      = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

   // field widths
   localparam int JOINT_W   = 4;
   localparam int NODE_W    = 7;
   localparam int CHAN_W    = 8;
   localparam int VAL_W     = 32;
   localparam int TIME_W    = 48;
   localparam int OUTCOME_W = 4;
   localparam int THR_W     = 31;
   localparam int TICKS_W   = 32;
   localparam int ATT_W     = 8;
   localparam int CNT_W     = 3;

   // stream payload widths
   localparam int REQ_W      = 136;
   localparam int REQ_USER_W = 1;
   localparam int RSP_W      = 24;
   localparam int RSP_USER_W = 2;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ATT   = 3'd5;

   // register reset values
   localparam logic [THR_W-1:0]   RST_THRESHOLD = 31'd6554;
   localparam logic [THR_W-1:0]   RST_EPSILON   = 31'd655;
   localparam logic [TICKS_W-1:0] RST_TIMEOUT   = 32'd2000000;
   localparam logic [TICKS_W-1:0] RST_RETRY     = 32'd10000000;
   localparam logic [ATT_W-1:0]   RST_MAX_ATT   = 8'd3;

   // low bits of the rpdo count, used when a repair count saturates
   localparam logic [CNT_W-1:0] RPDO_CNT_LO = CNT_W'(RPDO_COUNT);

   // request kinds
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_REPAIR = 1'b1;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_RESUME  = 2'd1,
      EV_REPAIR  = 2'd2,
      EV_STATUS  = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      CLS_REENABLED  = 2'd0,
      CLS_CFG_VALID  = 2'd1,
      CLS_UNREADABLE = 2'd2
   } class_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // one joint's entry in the state memory
   typedef struct packed {
      logic               armed;
      logic [TIME_W-1:0]  window_start;
      logic [VAL_W-1:0]   window_position;
      logic               reported;
      logic [ATT_W-1:0]   attempts;
      logic               fix_pending;
      logic [TIME_W-1:0]  last_attempt;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // captured request plus the command magnitude check
   typedef struct packed {
      logic                  op;
      logic [JOINT_W-1:0]    joint;
      logic [NODE_W-1:0]     node_id;
      logic [CHAN_W-1:0]     channel;
      logic [VAL_W-1:0]      position;
      logic                  drv_ready;
      logic [TIME_W-1:0]     now;
      logic [OUTCOME_W-1:0]  repair_outcome;
      logic                  cmd_hot;
   } item_type;

   typedef struct packed {
      logic                enable;
      logic [THR_W-1:0]    epsilon;
      logic [TICKS_W-1:0]  timeout;
      logic [TICKS_W-1:0]  retry;
      logic [ATT_W-1:0]    max_attempts;
   } cfg_type;

   typedef struct packed {
      logic       wr_en;
      entry_type  entry;
   } update_type;

   typedef struct packed {
      event_type           event_res;
      logic [JOINT_W-1:0]  event_joint;
      logic [NODE_W-1:0]   event_node;
      logic [CHAN_W-1:0]   event_channel;
      class_type           status_class;
      logic [CNT_W-1:0]    repaired_count;
   } result_type;

endpackage

// ----- design/dsw_ram.sv -----
// dsw_ram: generic single-write, single-read ram with registered read data
module dsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/dsw_eval.sv -----
// dsw_eval: per-request decision, entry update and result for one joint
module dsw_eval (
   input  dsw_pkg::cfg_type     cfg,
   input  dsw_pkg::item_type    item,
   input  dsw_pkg::entry_type   entry,
   output dsw_pkg::update_type  upd,
   output dsw_pkg::result_type  res
);

   import dsw_pkg::*;

   logic signed [VAL_W:0] pos_diff;
   logic [VAL_W:0]        pos_mag;
   logic                  moved;
   logic [TIME_W-1:0]     elapsed;
   logic [TIME_W-1:0]     since_try;
   logic                  timed_out;
   logic                  cooling;
   logic                  joint_ok;
   logic                  out_pos;
   logic                  out_zero;
   logic                  out_sat;

   // movement since the window opened, exact in 33 bits
   assign pos_diff = {item.position[VAL_W-1], item.position}
                   - {entry.window_position[VAL_W-1], entry.window_position};
   assign pos_mag  = pos_diff[VAL_W] ? (~pos_diff + 1'b1) : pos_diff;
   assign moved    = pos_mag > {2'b00, cfg.epsilon};

   // tick differences wrap with the time base
   assign elapsed   = item.now - entry.window_start;
   assign since_try = item.now - entry.last_attempt;
   assign timed_out = elapsed >= {16'h0000, cfg.timeout};
   assign cooling   = (entry.attempts != '0) && (since_try < {16'h0000, cfg.retry});

   assign joint_ok = 32'(item.joint) < JOINT_COUNT;

   assign out_zero = item.repair_outcome == '0;
   assign out_pos  = !item.repair_outcome[OUTCOME_W-1] && !out_zero;
   assign out_sat  = 32'(item.repair_outcome) > RPDO_COUNT;

   always_comb begin
      upd       = '{wr_en: 1'b0, entry: entry};
      res       = '0;
      res.event_res    = EV_NONE;
      res.status_class = CLS_REENABLED;

      if (joint_ok) begin
         if (item.op == OP_REPAIR) begin
            upd.wr_en                = 1'b1;
            upd.entry.fix_pending    = 1'b0;
            upd.entry.reported       = 1'b1;
            res.event_res     = EV_STATUS;
            res.event_joint   = item.joint;
            res.event_channel = item.channel;
            if (out_pos) begin
               res.status_class   = CLS_REENABLED;
               res.repaired_count = out_sat ? RPDO_CNT_LO : item.repair_outcome[CNT_W-1:0];
            end else if (out_zero) begin
               res.status_class = CLS_CFG_VALID;
            end else begin
               res.status_class = CLS_UNREADABLE;
            end
         end else if (cfg.enable) begin
            if (!item.cmd_hot || !item.drv_ready) begin
               upd.wr_en       = 1'b1;
               upd.entry.armed = 1'b0;
            end else if (!entry.armed) begin
               upd.wr_en                 = 1'b1;
               upd.entry.armed           = 1'b1;
               upd.entry.window_start    = item.now;
               upd.entry.window_position = item.position;
            end else if (moved) begin
               upd.wr_en                 = 1'b1;
               upd.entry.window_start    = item.now;
               upd.entry.window_position = item.position;
               if (entry.reported || (entry.attempts != '0)) begin
                  upd.entry.reported = 1'b0;
                  upd.entry.attempts = '0;
                  res.event_res      = EV_RESUME;
                  res.event_joint    = item.joint;
                  res.event_channel  = item.channel;
               end
            end else if (timed_out && !entry.fix_pending
                         && (entry.attempts < cfg.max_attempts) && !cooling) begin
               upd.wr_en                = 1'b1;
               upd.entry.attempts       = entry.attempts + 1'b1;
               upd.entry.last_attempt   = item.now;
               upd.entry.fix_pending    = 1'b1;
               res.event_res     = EV_REPAIR;
               res.event_joint   = item.joint;
               res.event_node    = item.node_id;
               res.event_channel = item.channel;
            end
         end
      end
   end

endmodule

// ----- design/drive_stall_watchdog.sv -----
// drive_stall_watchdog: per-joint stall watchdog top level around a joint state ram
//
//   group  direction  handshake              payload
//   req    in         req_tvalid/req_tready  tdata: sample or repair report, tuser: op
//   rsp    out        rsp_tvalid/rsp_tready  tdata: event fields, tuser: event code
//   csr    in         csr_valid/csr_ready    csr_index, csr_data
//
// for each request the accept cycle reads the joint entry from the ram, and the exec
// state then decides, writes the entry back and loads the response register
// one request is in flight at a time; the ram read-modify-write sets the rate
// a request may be accepted while the previous response still waits on rsp_tready;
// the exec state holds until the response register is free
// reset clears the control state, the registers to their defaults and the per-joint
// valid bits; an entry never written reads as zero, so no clearing pass is needed
module drive_stall_watchdog (
   input  logic                               clock,
   input  logic                               reset,
   // request: joint[3:0] node_id[10:4] channel[18:11] command[50:19] position[82:51]
   //   drv_ready[83] now[131:84] repair_outcome[135:132]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dsw_pkg::REQ_W-1:0]          req_tdata,
   // request user: op[0]
   input  logic [dsw_pkg::REQ_USER_W-1:0]     req_tuser,
   // response: event_joint[3:0] event_node[10:4] event_channel[18:11]
   //   status_class[20:19] repaired_count[23:21]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dsw_pkg::RSP_W-1:0]          rsp_tdata,
   // response user: event_res[1:0]
   output logic [dsw_pkg::RSP_USER_W-1:0]     rsp_tuser,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dsw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dsw_pkg::CSR_DATA_W-1:0]     csr_data
);

   import dsw_pkg::*;

   state_type state_ff, state_in;

   // configuration registers
   logic                enable_ff;
   logic [THR_W-1:0]    threshold_ff;
   logic [THR_W-1:0]    epsilon_ff;
   logic [TICKS_W-1:0]  timeout_ff;
   logic [TICKS_W-1:0]  retry_ff;
   logic [ATT_W-1:0]    max_att_ff;
   logic                csr_fire;

   // request capture
   item_type            item_ff, item_in;
   logic                req_fire;
   logic [VAL_W-1:0]    req_command;
   logic [VAL_W:0]      cmd_mag;

   // joint state ram
   logic [JIDX_W-1:0]   rd_addr;
   logic [JIDX_W-1:0]   cur_idx;
   logic [ENTRY_W-1:0]  ram_q;
   logic [JOINT_COUNT-1:0] valid_ff;
   entry_type           entry_rd;
   logic                ram_we;

   // decision and response
   cfg_type             cfg;
   update_type          upd;
   result_type          res;
   result_type          rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                exec_go;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         threshold_ff <= RST_THRESHOLD;
         epsilon_ff   <= RST_EPSILON;
         timeout_ff   <= RST_TIMEOUT;
         retry_ff     <= RST_RETRY;
         max_att_ff   <= RST_MAX_ATT;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_ENABLE:    enable_ff    <= csr_data[0];
            CSR_THRESHOLD: threshold_ff <= csr_data[THR_W-1:0];
            CSR_EPSILON:   epsilon_ff   <= csr_data[THR_W-1:0];
            CSR_TIMEOUT:   timeout_ff   <= csr_data[TICKS_W-1:0];
            CSR_RETRY:     retry_ff     <= csr_data[TICKS_W-1:0];
            CSR_MAX_ATT:   max_att_ff   <= csr_data[ATT_W-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   assign cfg = '{enable: enable_ff, epsilon: epsilon_ff, timeout: timeout_ff,
                  retry: retry_ff, max_attempts: max_att_ff};

   // ---------------- request unpack ----------------
   // command magnitude is checked on the way in; most negative value gives 2^31
   assign req_command = req_tdata[50:19];
   assign cmd_mag     = req_command[VAL_W-1] ? (~{1'b1, req_command} + 1'b1)
                                             : {1'b0, req_command};

   always_comb begin
      item_in.op             = req_tuser[0];
      item_in.joint          = req_tdata[3:0];
      item_in.node_id        = req_tdata[10:4];
      item_in.channel        = req_tdata[18:11];
      item_in.position       = req_tdata[82:51];
      item_in.drv_ready      = req_tdata[83];
      item_in.now            = req_tdata[131:84];
      item_in.repair_outcome = req_tdata[135:132];
      item_in.cmd_hot        = cmd_mag > {2'b00, threshold_ff};
   end

   assign req_fire = req_tvalid && req_tready;

   // payload capture, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
   end

   // ---------------- sequencer ----------------
   // the exec state proceeds only when the response register can take the result
   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_EXEC: req_tready = 1'b0;
         default: req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- joint state ram ----------------
   // read at the incoming joint while idle, then keep the captured joint on the
   // address so the read data stays put through a response stall
   assign cur_idx = JIDX_W'(item_ff.joint);
   assign rd_addr = (state_ff == ST_IDLE) ? JIDX_W'(item_in.joint) : cur_idx;
   assign ram_we  = exec_go && upd.wr_en;

   dsw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (JOINT_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cur_idx),
      .wr_data (upd.entry),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // an entry never written since reset reads as all zero
   assign entry_rd = valid_ff[cur_idx] ? entry_type'(ram_q) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[cur_idx] <= 1'b1;
      end
   end

   // ---------------- decision ----------------
   dsw_eval u_eval (
      .cfg   (cfg),
      .item  (item_ff),
      .entry (entry_rd),
      .upd   (upd),
      .res   (res)
   );

   // ---------------- response register ----------------
   // every request yields exactly one response, event_res none included
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.repaired_count, rsp_ff.status_class, rsp_ff.event_channel,
                        rsp_ff.event_node, rsp_ff.event_joint};
   assign rsp_tuser  = rsp_ff.event_res;

endmodule

// ----- dv/dsw_event_checker.sv -----
// dsw_event_checker: watches the watchdog channels, predicts each response and compares
module dsw_event_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [dsw_pkg::REQ_W-1:0]          req_tdata,
   input  logic [dsw_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [dsw_pkg::RSP_W-1:0]          rsp_tdata,
   input  logic [dsw_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [dsw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dsw_pkg::CSR_DATA_W-1:0]     csr_data,
   output int                                 mismatches,
   output int                                 outstanding,
   output int                                 n_quiet,
   output int                                 n_resume,
   output int                                 n_repair,
   output int                                 n_status
);

   timeunit 1ns;
   timeprecision 1ps;

   import dsw_pkg::*;

   // register copies
   logic                c_enable;
   logic [THR_W-1:0]    c_threshold;
   logic [THR_W-1:0]    c_epsilon;
   logic [TICKS_W-1:0]  c_timeout;
   logic [TICKS_W-1:0]  c_retry;
   logic [ATT_W-1:0]    c_max_att;

   // per-joint table
   logic                j_armed     [JOINT_COUNT];
   logic [TIME_W-1:0]   j_win_start [JOINT_COUNT];
   logic [VAL_W-1:0]    j_win_pos   [JOINT_COUNT];
   logic                j_reported  [JOINT_COUNT];
   logic [ATT_W-1:0]    j_attempts  [JOINT_COUNT];
   logic                j_pending   [JOINT_COUNT];
   logic [TIME_W-1:0]   j_last_try  [JOINT_COUNT];

   result_type expected_events [$];
   int         n_checked;

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("%t: response %0d %s: got %0h, expected %0h", $realtime, n_checked, field,
               got, want);
      mismatches++;
   endtask

   task automatic predict_event(
      input  logic               op,
      input  logic [JOINT_W-1:0] jt,
      input  logic [NODE_W-1:0]  node,
      input  logic [CHAN_W-1:0]  ch,
      input  logic [VAL_W-1:0]   cmd,
      input  logic [VAL_W-1:0]   pos,
      input  logic               rdy,
      input  logic [TIME_W-1:0]  tnow,
      input  logic [3:0]         outcome,
      output result_type         ev
   );
      logic [32:0]        cmd_mag;
      logic signed [33:0] dpos;
      logic [33:0]        dpos_mag;
      logic [TIME_W-1:0]  since_window;
      logic [TIME_W-1:0]  since_try;
      ev = '0;
      if (int'(jt) >= JOINT_COUNT) return;

      if (op == OP_REPAIR) begin
         if (!outcome[3] && outcome != 4'd0) begin
            ev.status_class = CLS_REENABLED;
            ev.repaired_count = (int'(outcome) > RPDO_COUNT) ? RPDO_CNT_LO : outcome[2:0];
         end else if (outcome == 4'd0) begin
            ev.status_class = CLS_CFG_VALID;
         end else begin
            ev.status_class = CLS_UNREADABLE;
         end
         j_pending[jt] = 1'b0;
         j_reported[jt] = 1'b1;
         ev.event_res = EV_STATUS;
         ev.event_joint = jt;
         ev.event_channel = ch;
         return;
      end

      if (!c_enable) return;

      // magnitude in 33 bits so the most negative command stays positive
      cmd_mag = cmd[31] ? (33'd0 - {1'b1, cmd}) : {1'b0, cmd};
      if (cmd_mag <= {2'b00, c_threshold} || !rdy) begin
         j_armed[jt] = 1'b0;
         return;
      end

      if (!j_armed[jt]) begin
         j_armed[jt] = 1'b1;
         j_win_start[jt] = tnow;
         j_win_pos[jt] = pos;
         return;
      end

      dpos = $signed({{2{pos[31]}}, pos}) - $signed({{2{j_win_pos[jt][31]}}, j_win_pos[jt]});
      dpos_mag = dpos[33] ? 34'(-dpos) : 34'(dpos);
      if (dpos_mag > {3'b000, c_epsilon}) begin
         j_win_start[jt] = tnow;
         j_win_pos[jt] = pos;
         if (j_reported[jt] || j_attempts[jt] != '0) begin
            j_reported[jt] = 1'b0;
            j_attempts[jt] = '0;
            ev.event_res = EV_RESUME;
            ev.event_joint = jt;
            ev.event_channel = ch;
         end
         return;
      end

      since_window = tnow - j_win_start[jt];
      if (since_window < {16'd0, c_timeout}) return;
      if (j_pending[jt] || j_attempts[jt] >= c_max_att) return;
      since_try = tnow - j_last_try[jt];
      if (j_attempts[jt] != '0 && since_try < {16'd0, c_retry}) return;

      j_attempts[jt] = j_attempts[jt] + 1'b1;
      j_last_try[jt] = tnow;
      j_pending[jt] = 1'b1;
      ev.event_res = EV_REPAIR;
      ev.event_joint = jt;
      ev.event_node = node;
      ev.event_channel = ch;
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      result_type predicted;
      if (reset) begin
         c_enable = 1'b1;
         c_threshold = RST_THRESHOLD;
         c_epsilon = RST_EPSILON;
         c_timeout = RST_TIMEOUT;
         c_retry = RST_RETRY;
         c_max_att = RST_MAX_ATT;
         for (int i = 0; i < JOINT_COUNT; i++) begin
            j_armed[i] = 1'b0;
            j_win_start[i] = '0;
            j_win_pos[i] = '0;
            j_reported[i] = 1'b0;
            j_attempts[i] = '0;
            j_pending[i] = 1'b0;
            j_last_try[i] = '0;
         end
         expected_events.delete();
         mismatches = 0;
         n_checked = 0;
         n_quiet = 0;
         n_resume = 0;
         n_repair = 0;
         n_status = 0;
         outstanding <= 0;
      end else begin
         // a response at this edge always belongs to an earlier request
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               report("arrived with nothing outstanding", 32'(rsp_tuser), '0);
            end else begin
               want = expected_events[0];
               expected_events.delete(0);
               if (rsp_tuser != want.event_res)
                  report("event_res", 32'(rsp_tuser), 32'(want.event_res));
               if (rsp_tdata[3:0] != want.event_joint)
                  report("event_joint", 32'(rsp_tdata[3:0]), 32'(want.event_joint));
               if (rsp_tdata[10:4] != want.event_node)
                  report("event_node", 32'(rsp_tdata[10:4]), 32'(want.event_node));
               if (rsp_tdata[18:11] != want.event_channel)
                  report("event_channel", 32'(rsp_tdata[18:11]), 32'(want.event_channel));
               if (rsp_tdata[20:19] != want.status_class)
                  report("status_class", 32'(rsp_tdata[20:19]), 32'(want.status_class));
               if (rsp_tdata[23:21] != want.repaired_count)
                  report("repaired_count", 32'(rsp_tdata[23:21]),
                         32'(want.repaired_count));
               case (want.event_res)
                  EV_RESUME: n_resume++;
                  EV_REPAIR: n_repair++;
                  EV_STATUS: n_status++;
                  default:   n_quiet++;
               endcase
            end
            n_checked++;
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE:    c_enable = csr_data[0];
               CSR_THRESHOLD: c_threshold = csr_data[THR_W-1:0];
               CSR_EPSILON:   c_epsilon = csr_data[THR_W-1:0];
               CSR_TIMEOUT:   c_timeout = csr_data;
               CSR_RETRY:     c_retry = csr_data;
               CSR_MAX_ATT:   c_max_att = csr_data[ATT_W-1:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            predict_event(req_tuser[0], req_tdata[3:0], req_tdata[10:4], req_tdata[18:11],
                          req_tdata[50:19], req_tdata[82:51], req_tdata[83],
                          req_tdata[131:84], req_tdata[135:132], predicted);
            expected_events.insert(expected_events.size(), predicted);
         end

         outstanding <= expected_events.size();
      end
   end

endmodule

// ----- dv/drive_stall_watchdog_tb.sv -----
// drive_stall_watchdog_tb: stimulus, idling, watchdog and verdict for the stall watchdog
module drive_stall_watchdog_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import dsw_pkg::*;

   localparam int IDLE_LIMIT = 2000;  // cycles with no handshake before giving up
   localparam int TAIL_WAIT  = 10;    // cycles after the last response
   localparam int PHASE_LEN  = 130;   // random requests per register setting

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_W-1:0]        req_tdata;
   logic [REQ_USER_W-1:0]   req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_W-1:0]        rsp_tdata;
   logic [RSP_USER_W-1:0]   rsp_tuser;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   int mismatches;
   int outstanding;
   int n_quiet;
   int n_resume;
   int n_repair;
   int n_status;

   // stimulus bookkeeping
   logic [TIME_W-1:0]  tick;              // running time base for well-formed samples
   logic [VAL_W-1:0]   jpos [JOINT_COUNT];// nominal resting position per joint
   logic [THR_W-1:0]   thr_now;
   logic [THR_W-1:0]   eps_now;
   logic [TICKS_W-1:0] tmo_now;
   logic [1:0]         grp;               // joint group favored by the current phase
   bit                 send_burst;        // sender runs without gaps
   bit                 take_burst;        // receiver runs without stalls
   int                 n_sent;
   int                 n_cfg;
   int                 n_settings;
   int                 idle_cycles;

   drive_stall_watchdog dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   dsw_event_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .n_quiet     (n_quiet),
      .n_resume    (n_resume),
      .n_repair    (n_repair),
      .n_status    (n_status)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: any cycle without a handshake on some channel counts toward the limit
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%t: no handshake for %0d cycles, %0d responses outstanding",
                  $realtime, idle_cycles, outstanding);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side: a fresh random stall, possibly none, before each response,
   // with runs of back-to-back acceptance now and then
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      take_burst = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
         stall = take_burst ? 0 : $urandom_range(0, 13);
         // lower ready only when there is a stall, so it is never lowered and
         // raised again in the same step
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // one request: random gap, then hold valid until the block takes it
   // entered and left at a rising edge; valid stays high for a gap-free follower
   task automatic send_req(
      input logic              op,
      input logic [JOINT_W-1:0] jt,
      input logic [NODE_W-1:0] node,
      input logic [CHAN_W-1:0] ch,
      input logic [VAL_W-1:0]  cmd,
      input logic [VAL_W-1:0]  pos,
      input logic              rdy,
      input logic [TIME_W-1:0] tnow,
      input logic [3:0]        outcome
   );
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {outcome, tnow, rdy, pos, cmd, ch, node, jt};
      do @(posedge clock); while (!req_tready);
      n_sent++;
   endtask

   // hold the sender until every response is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      n_cfg++;
   endtask

   // registers change only with the block idle
   task automatic apply_settings(
      input logic               en,
      input logic [THR_W-1:0]   thr,
      input logic [THR_W-1:0]   eps,
      input logic [TICKS_W-1:0] tmo,
      input logic [TICKS_W-1:0] retry,
      input logic [ATT_W-1:0]   max_att
   );
      wait_drained();
      csr_write(CSR_ENABLE, {31'd0, en});
      csr_write(CSR_THRESHOLD, {1'b0, thr});
      csr_write(CSR_EPSILON, {1'b0, eps});
      csr_write(CSR_TIMEOUT, tmo);
      csr_write(CSR_RETRY, retry);
      csr_write(CSR_MAX_ATT, {24'd0, max_att});
      thr_now = thr;
      eps_now = eps;
      tmo_now = tmo;
      n_settings++;
   endtask

   // command magnitude above the threshold; the most negative value beats any threshold
   function automatic logic [VAL_W-1:0] hot_command();
      logic [VAL_W-1:0] mag;
      if (thr_now > 31'h7FFF_F000 || $urandom_range(0, 15) == 0) return 32'h8000_0000;
      mag = {1'b0, thr_now} + 32'd1 + 32'($urandom_range(0, 4095));
      return ($urandom_range(0, 1) != 0) ? -mag : mag;
   endfunction

   // command magnitude at or below the threshold
   function automatic logic [VAL_W-1:0] cold_command();
      logic [VAL_W-1:0] mag;
      mag = $urandom_range(0, {1'b0, thr_now});
      return ($urandom_range(0, 1) != 0) ? -mag : mag;
   endfunction

   // resting position plus jitter of at most half the movement threshold
   function automatic logic [VAL_W-1:0] rest_position(input logic [JOINT_W-1:0] jt);
      logic [VAL_W-1:0] jitter;
      jitter = $urandom_range(0, {1'b0, eps_now} >> 1);
      return ($urandom_range(0, 1) != 0) ? jpos[jt] - jitter : jpos[jt] + jitter;
   endfunction

   // one random request: mostly well-formed stall and repair traffic on a small
   // group of joints, plus disarming samples and plain noise
   task automatic random_item();
      int               pick;
      int unsigned      step_max;
      logic [JOINT_W-1:0] jt;
      logic [VAL_W-1:0] step;
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      // every so often let everything drain in the middle of a phase
      if ($urandom_range(0, 99) == 0) wait_drained();
      pick = $urandom_range(0, 99);
      jt = ($urandom_range(0, 9) < 7) ? {grp, 2'($urandom_range(0, 3))} : 4'($urandom);
      // time steps sized so a stall window closes within a handful of samples
      step_max = tmo_now / 6 + 1;
      tick = tick + 48'($urandom_range(1, step_max));
      if (pick < 50) begin
         // stalled joint: command hot, drive ready, position at rest
         send_req(OP_SAMPLE, jt, 7'($urandom), 8'($urandom), hot_command(),
                  rest_position(jt), 1'b1, tick, 4'($urandom));
      end else if (pick < 60) begin
         // real movement: either just past epsilon or a wild jump
         step = ($urandom_range(0, 1) != 0) ? 32'($urandom) :
                {1'b0, eps_now} + 32'd1 + 32'($urandom_range(0, 100));
         jpos[jt] = ($urandom_range(0, 1) != 0) ? jpos[jt] + step : jpos[jt] - step;
         send_req(OP_SAMPLE, jt, 7'($urandom), 8'($urandom), hot_command(), jpos[jt],
                  1'b1, tick, 4'($urandom));
      end else if (pick < 73) begin
         // repair finished, any outcome
         send_req(OP_REPAIR, jt, 7'($urandom), 8'($urandom), 32'($urandom), 32'($urandom),
                  1'($urandom), tick, 4'($urandom));
      end else if (pick < 85) begin
         // disarm: command too small, or drive not ready
         if ($urandom_range(0, 1) != 0)
            send_req(OP_SAMPLE, jt, 7'($urandom), 8'($urandom), cold_command(),
                     rest_position(jt), 1'($urandom), tick, 4'($urandom));
         else
            send_req(OP_SAMPLE, jt, 7'($urandom), 8'($urandom), hot_command(),
                     rest_position(jt), 1'b0, tick, 4'($urandom));
      end else begin
         // noise: every field random, time included
         send_req(1'($urandom), 4'($urandom), 7'($urandom), 8'($urandom), 32'($urandom),
                  32'($urandom), 1'($urandom), {16'($urandom), 32'($urandom)},
                  4'($urandom));
      end
   endtask

   task automatic run_phase();
      grp = 2'($urandom);
      repeat (PHASE_LEN) random_item();
   endtask

   initial begin
      logic [VAL_W-1:0] hot;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      reset      <= 1'b1;
      tick = '0;
      for (int i = 0; i < JOINT_COUNT; i++) jpos[i] = '0;
      thr_now = RST_THRESHOLD;
      eps_now = RST_EPSILON;
      tmo_now = RST_TIMEOUT;
      grp = '0;
      send_burst = 1'b0;
      n_sent = 0;
      n_cfg = 0;
      n_settings = 1;
      hot = 32'd5000;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // short windows so stalls and cooldowns show up within a few samples
      apply_settings(1'b1, 31'd100, 31'd10, 32'd20, 32'd50, 8'd2);
      // arm, stay inside epsilon, then stall into a first repair request
      send_req(OP_SAMPLE, 4'd5, 7'h7F, 8'hFF, hot, 32'd0, 1'b1, 48'd1000, 4'd0);
      send_req(OP_SAMPLE, 4'd5, 7'h7F, 8'hFF, hot, 32'd5, 1'b1, 48'd1010, 4'd0);
      send_req(OP_SAMPLE, 4'd5, 7'h7F, 8'hFF, -hot, 32'd5, 1'b1, 48'd1030, 4'd0);
      // repair still pending: nothing
      send_req(OP_SAMPLE, 4'd5, 7'h7F, 8'hFF, hot, 32'd5, 1'b1, 48'd1040, 4'd0);
      // repair report with a positive count
      send_req(OP_REPAIR, 4'd5, 7'h7F, 8'hFF, '0, '0, 1'b0, 48'd1045, 4'd3);
      // cooldown not yet over, then over: second request
      send_req(OP_SAMPLE, 4'd5, 7'h7F, 8'hFF, hot, 32'd5, 1'b1, 48'd1060, 4'd0);
      send_req(OP_SAMPLE, 4'd5, 7'h7F, 8'hFF, hot, 32'd5, 1'b1, 48'd1085, 4'd0);
      // config valid report, then the attempt limit blocks a third request
      send_req(OP_REPAIR, 4'd5, 7'h7F, 8'hFF, '0, '0, 1'b0, 48'd1090, 4'd0);
      send_req(OP_SAMPLE, 4'd5, 7'h7F, 8'hFF, hot, 32'd5, 1'b1, 48'd1200, 4'd0);
      // movement after repairs: motion resumed
      send_req(OP_SAMPLE, 4'd5, 7'h7F, 8'hFF, hot, 32'd100, 1'b1, 48'd1210, 4'd0);
      // reports with no repair pending: unreadable, below minus one, count saturating
      send_req(OP_REPAIR, 4'd5, 7'h00, 8'h00, '0, '0, 1'b1, 48'd1220, 4'hF);
      send_req(OP_REPAIR, 4'd5, 7'h00, 8'h00, '0, '0, 1'b1, 48'd1221, 4'h8);
      send_req(OP_REPAIR, 4'd5, 7'h00, 8'h00, '0, '0, 1'b1, 48'd1222, 4'h7);
      // most negative command arms joint 0 just before the time base wraps
      send_req(OP_SAMPLE, 4'd0, 7'h00, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
               48'hFFFF_FFFF_FFFB, 4'd0);
      // stall measured across the wrap
      send_req(OP_SAMPLE, 4'd0, 7'h2A, 8'h55, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
               48'd20, 4'd0);
      // largest possible position swing counts as movement and resumes
      send_req(OP_SAMPLE, 4'd0, 7'h2A, 8'h55, 32'h8000_0000, 32'h8000_0000, 1'b1,
               48'd30, 4'd0);
      // command exactly at the threshold disarms, so does a drive not ready
      send_req(OP_SAMPLE, 4'd0, 7'h01, 8'h01, 32'd100, 32'h8000_0000, 1'b1, 48'd40, 4'd0);
      send_req(OP_SAMPLE, 4'd0, 7'h01, 8'h01, hot, 32'h8000_0000, 1'b0, 48'd50, 4'd0);
      // one above the threshold, negative, arms the last joint
      send_req(OP_SAMPLE, 4'd15, 7'h7F, 8'hFF, -32'd101, 32'hFFFF_FFFF, 1'b1, 48'd60, 4'hF);
      // disabled: samples do nothing, repair reports still answered
      apply_settings(1'b0, 31'd100, 31'd10, 32'd20, 32'd50, 8'd2);
      send_req(OP_SAMPLE, 4'd15, 7'h7F, 8'hFF, hot, 32'd0, 1'b1, 48'd500, 4'd0);
      send_req(OP_REPAIR, 4'd15, 7'h7F, 8'hFF, hot, 32'd0, 1'b1, 48'd510, 4'd1);

      // ---- random part, one phase per register setting ----
      tick = 48'd1000;
      apply_settings(1'b1, RST_THRESHOLD, RST_EPSILON, RST_TIMEOUT, RST_RETRY, RST_MAX_ATT);
      run_phase();
      // all registers but enable at their low extreme
      apply_settings(1'b1, '0, '0, '0, '0, '0);
      run_phase();
      apply_settings(1'b1, 31'd1000, 31'd200, 32'd300, 32'd700, 8'd2);
      run_phase();
      // all registers at their high extreme
      apply_settings(1'b1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     8'hFF);
      run_phase();
      apply_settings(1'b0, 31'd1000, 31'd200, 32'd300, 32'd700, 8'd2);
      run_phase();
      // time base starts just short of the wrap
      tick = 48'hFFFF_FFFF_F000;
      apply_settings(1'b1, 31'd50000, 31'd1000, 32'd100, 32'd0, 8'hFF);
      run_phase();
      apply_settings(1'b1, 31'd20000, 31'd50, 32'd2000, 32'd5000, 8'd1);
      run_phase();

      // ---- wind down ----
      wait_drained();
      repeat (TAIL_WAIT) @(posedge clock);

      $display("sent %0d requests under %0d register settings (%0d register writes)",
               n_sent, n_settings, n_cfg);
      $display("responses: %0d quiet, %0d motion resumed, %0d repair requests, %0d status",
               n_quiet, n_resume, n_repair, n_status);
      if (mismatches == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d responses outstanding", mismatches, outstanding);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
